>>> rtl/kst_pkg.sv
package kst_pkg;

  typedef enum logic [1:0] {
    OP_SEARCH = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_CLEAR  = 2'd3
  } kst_op_e;

  typedef enum logic [1:0] {
    STAT_DONE    = 2'd0,
    STAT_PRESENT = 2'd1,
    STAT_ABSENT  = 2'd2,
    STAT_FULL    = 2'd3
  } kst_status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } kst_state_e;

  localparam int unsigned KeyW   = 32;
  localparam int unsigned CountW = 5;

endpackage

>>> rtl/kst_key_ram.sv
module kst_key_ram #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4,
  parameter int unsigned DataW = 32
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [DataW-1:0] wr_data_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [DataW-1:0] rd_data_o
);

  logic [DataW-1:0] mem_q [Depth];
  logic [DataW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> rtl/key_set_table_unit.sv
// Set of unique signed 32-bit keys held in CAPACITY slots.
// Requests: raise start with req_type_i and key_i; the beat is taken on a
// clock edge where start is high and busy is low. req_type_i selects search,
// insert, delete or clear.
// Every request gives one result beat: done_o is high for exactly one cycle
// with found_o (key held before the request, low for a clear), status_o and entry_count_o
// (keys held afterwards). The receiver cannot stall; the result is simply
// presented for that one cycle.
// Timing: search, insert and delete read the key memory one slot a cycle
// through its single registered read port, stopping at the first matching
// slot or after the last slot, and then update the table in S_FINISH. A
// clear goes to S_FINISH without a scan. busy stays high until the table
// has been updated, and the next request may be accepted in the cycle
// done_o is shown.
// Reset: all slots are marked empty and the count is zero at once; the key
// memory itself is not cleared and only slots marked valid are compared.
module key_set_table_unit
  import kst_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        req_type_i,
  input  logic signed [31:0] key_i,
  output logic              done_o,
  output logic              found_o,
  output logic [1:0]        status_o,
  output logic [4:0]        entry_count_o
);

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(CAPACITY - 1);

  kst_state_e state_q, state_d;
  kst_op_e    op_q;
  logic [KeyW-1:0] key_q;

  logic [IdxW-1:0] scan_idx_q, scan_idx_d;
  logic            issue_done_q, issue_done_d;
  logic            cmp_en_q, cmp_en_d;
  logic [IdxW-1:0] cmp_idx_q;
  logic            hit_q, hit_d;
  logic [IdxW-1:0] hit_idx_q, hit_idx_d;
  logic            free_q, free_d;
  logic [IdxW-1:0] free_idx_q, free_idx_d;

  logic [CAPACITY-1:0] valid_q, valid_d;
  logic [CntW-1:0]     count_q, count_d;

  logic            done_q;
  logic            found_q, found_d;
  kst_status_e     status_q, status_d;
  logic [CountW-1:0] entry_q, entry_d;
  logic [CntW+CountW-1:0] count_ext;

  logic            accept;
  logic [KeyW-1:0] rd_data;
  logic            wr_en;
  logic            cmp_hit, cmp_free, cmp_last, scan_end;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);

  kst_key_ram #(
    .Depth (CAPACITY),
    .AddrW (IdxW),
    .DataW (KeyW)
  ) u_key_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (free_idx_q),
    .wr_data_i (key_q),
    .rd_addr_i (scan_idx_q),
    .rd_data_o (rd_data)
  );

  // compare stage, on the slot addressed in the previous cycle
  assign cmp_hit  = cmp_en_q && valid_q[cmp_idx_q] && (rd_data == key_q);
  assign cmp_free = cmp_en_q && !valid_q[cmp_idx_q];
  assign cmp_last = cmp_en_q && (cmp_idx_q == LastIdx);
  assign scan_end = cmp_hit || cmp_last;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = (kst_op_e'(req_type_i) == OP_CLEAR) ? S_FINISH : S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // scan control
  always_comb begin
    scan_idx_d   = scan_idx_q;
    issue_done_d = issue_done_q;
    cmp_en_d     = 1'b0;
    hit_d        = hit_q;
    hit_idx_d    = hit_idx_q;
    free_d       = free_q;
    free_idx_d   = free_idx_q;
    if (accept) begin
      scan_idx_d   = '0;
      issue_done_d = 1'b0;
      hit_d        = 1'b0;
      free_d       = 1'b0;
    end else if (state_q == S_SCAN) begin
      cmp_en_d = !issue_done_q && !scan_end;
      if (!issue_done_q) begin
        if (scan_idx_q == LastIdx) begin
          issue_done_d = 1'b1;
        end else begin
          scan_idx_d = scan_idx_q + IdxW'(1);
        end
      end
      if (cmp_hit) begin
        hit_d     = 1'b1;
        hit_idx_d = cmp_idx_q;
      end
      if (cmp_free && !free_q) begin
        free_d     = 1'b1;
        free_idx_d = cmp_idx_q;
      end
    end
  end

  // table update and result
  always_comb begin
    valid_d  = valid_q;
    count_d  = count_q;
    wr_en    = 1'b0;
    found_d  = 1'b0;
    status_d = STAT_DONE;
    if (state_q == S_FINISH) begin
      found_d = hit_q && (op_q != OP_CLEAR);
      case (op_q)
        OP_SEARCH: begin
          status_d = STAT_DONE;
        end
        OP_INSERT: begin
          if (hit_q) begin
            status_d = STAT_PRESENT;
          end else if (free_q) begin
            wr_en               = 1'b1;
            valid_d[free_idx_q] = 1'b1;
            count_d             = count_q + CntW'(1);
          end else begin
            status_d = STAT_FULL;
          end
        end
        OP_DELETE: begin
          if (hit_q) begin
            valid_d[hit_idx_q] = 1'b0;
            if (count_q != '0) begin
              count_d = count_q - CntW'(1);
            end
          end else begin
            status_d = STAT_ABSENT;
          end
        end
        default: begin
          valid_d = '0;
          count_d = '0;
        end
      endcase
    end
  end

  assign count_ext = (CntW + CountW)'(count_d);
  assign entry_d   = count_ext[CountW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      issue_done_q <= 1'b0;
      cmp_en_q     <= 1'b0;
      hit_q        <= 1'b0;
      free_q       <= 1'b0;
      valid_q      <= '0;
      count_q      <= '0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      issue_done_q <= issue_done_d;
      cmp_en_q     <= cmp_en_d;
      hit_q        <= hit_d;
      free_q       <= free_d;
      valid_q      <= valid_d;
      count_q      <= count_d;
      done_q       <= (state_q == S_FINISH);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= kst_op_e'(req_type_i);
      key_q <= key_i;
    end
    scan_idx_q <= scan_idx_d;
    cmp_idx_q  <= scan_idx_q;
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
    if (state_q == S_FINISH) begin
      found_q  <= found_d;
      status_q <= status_d;
      entry_q  <= entry_d;
    end
  end

  assign done_o        = done_q;
  assign found_o       = found_q;
  assign status_o      = status_q;
  assign entry_count_o = entry_q;

`ifndef SYNTHESIS
  a_count_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == CntW'($countones(valid_q)))
    else $error("held count differs from number of valid slots");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("held count above capacity");

  a_done_after_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH) |=> done_q && (state_q == S_IDLE))
    else $error("result beat missing after table update");

  a_no_compare_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_SCAN) |-> !cmp_en_q)
    else $error("compare stage active outside a scan");

  a_write_only_absent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> !hit_q && free_q && !valid_q[free_idx_q])
    else $error("key written over an occupied slot");
`endif

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import kst_pkg::*;

  localparam int unsigned SLOTS          = 16;
  localparam int unsigned RANDOM_ITEMS   = 625;
  localparam int unsigned POOL_SIZE      = 24;
  localparam int unsigned WATCHDOG_LIMIT = 1000;

  typedef struct packed {
    logic              found;
    kst_status_e       status;
    logic [CountW-1:0] count;
  } set_outcome_t;

  typedef struct packed {
    kst_op_e         op;
    logic [KeyW-1:0] key;
    logic            typed;
    set_outcome_t    want;
  } req_row_t;

  logic              clk_i      = 1'b0;
  logic              rst_ni     = 1'b0;
  logic              start      = 1'b0;
  logic [1:0]        req_type_i = OP_SEARCH;
  logic [KeyW-1:0]   key_i      = '0;
  logic              busy;
  logic              done_o;
  logic              found_o;
  logic [1:0]        status_o;
  logic [CountW-1:0] entry_count_o;

  logic [KeyW-1:0] held_keys [SLOTS];
  bit              slot_used [SLOTS];
  int unsigned     keys_held = 0;

  set_outcome_t    pending_results [$];
  req_row_t        directed_rows [$];
  logic [KeyW-1:0] key_pool [POOL_SIZE];
  int unsigned     mismatch_count = 0;
  int unsigned     stall_cycles = 0;

  always #4 clk_i = ~clk_i;

  key_set_table_unit #(
    .CAPACITY(SLOTS)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .req_type_i   (req_type_i),
    .key_i        (key_i),
    .done_o       (done_o),
    .found_o      (found_o),
    .status_o     (status_o),
    .entry_count_o(entry_count_o)
  );

  function automatic set_outcome_t predict_request(kst_op_e op, logic [KeyW-1:0] k);
    set_outcome_t res;
    int           hit;
    int           vacant;
    res.found  = 1'b0;
    res.status = STAT_DONE;
    hit        = -1;
    vacant     = -1;
    if (op != OP_CLEAR) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (hit < 0 && slot_used[i] && held_keys[i] == k) hit = i;
      end
      res.found = (hit >= 0);
    end
    case (op)
      OP_SEARCH: ;
      OP_INSERT: begin
        if (hit >= 0) begin
          res.status = STAT_PRESENT;
        end else begin
          for (int i = 0; i < SLOTS; i++) begin
            if (vacant < 0 && !slot_used[i]) vacant = i;
          end
          if (vacant < 0) begin
            res.status = STAT_FULL;
          end else begin
            held_keys[vacant] = k;
            slot_used[vacant] = 1'b1;
            keys_held++;
          end
        end
      end
      OP_DELETE: begin
        if (hit >= 0) begin
          slot_used[hit] = 1'b0;
          if (keys_held > 0) keys_held--;
        end else begin
          res.status = STAT_ABSENT;
        end
      end
      default: begin
        for (int i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
        keys_held = 0;
      end
    endcase
    res.count = keys_held[CountW-1:0];
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_count++;
    $display("mismatch at %0t: %s", $time, msg);
  endtask

  function automatic void add_row(kst_op_e op, logic [KeyW-1:0] k, logic typed, logic f,
                                  kst_status_e s, int unsigned c);
    req_row_t row;
    row.op          = op;
    row.key         = k;
    row.typed       = typed;
    row.want.found  = f;
    row.want.status = s;
    row.want.count  = c[CountW-1:0];
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  task automatic send_request(kst_op_e op, logic [KeyW-1:0] k, logic typed,
                              set_outcome_t want);
    set_outcome_t predicted;
    start      <= 1'b1;
    req_type_i <= op;
    key_i      <= k;
    do @(posedge clk_i); while (busy);
    predicted = predict_request(op, k);
    pending_results.insert(pending_results.size(), typed ? want : predicted);
  endtask

  task automatic idle_for(int unsigned cycles);
    if (cycles != 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  task automatic drain_pending();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // result beats: compare against the oldest expectation
  always @(posedge clk_i) begin : result_check
    set_outcome_t wanted;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing pending");
      end else begin
        wanted = pending_results.pop_front();
        if (found_o !== wanted.found)
          report_mismatch($sformatf("found_o got %b want %b", found_o, wanted.found));
        if (status_o !== wanted.status)
          report_mismatch($sformatf("status_o got %0d want %0d", status_o, wanted.status));
        if (entry_count_o !== wanted.count)
          report_mismatch($sformatf("entry_count_o got %0d want %0d", entry_count_o,
                                    wanted.count));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL key_set_table_unit");
        $finish;
      end
    end
  end

  initial begin
    int unsigned     gap;
    int unsigned     r;
    int unsigned     slot;
    kst_op_e         op;
    logic [KeyW-1:0] k;
    bit              filling;
    req_row_t        row;

    for (int i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7fff_ffff;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hffff_ffff;
    for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom();

    add_row(OP_SEARCH, 32'h0000_0000, 1'b1, 1'b0, STAT_DONE,    0);
    add_row(OP_DELETE, 32'h0000_0005, 1'b1, 1'b0, STAT_ABSENT,  0);
    add_row(OP_INSERT, 32'h8000_0000, 1'b1, 1'b0, STAT_DONE,    1);
    add_row(OP_INSERT, 32'h7fff_ffff, 1'b1, 1'b0, STAT_DONE,    2);
    add_row(OP_INSERT, 32'h8000_0000, 1'b1, 1'b1, STAT_PRESENT, 2);
    add_row(OP_SEARCH, 32'h7fff_ffff, 1'b1, 1'b1, STAT_DONE,    2);
    add_row(OP_DELETE, 32'h8000_0000, 1'b1, 1'b1, STAT_DONE,    1);
    add_row(OP_INSERT, 32'h0000_0000, 1'b1, 1'b0, STAT_DONE,    2);
    add_row(OP_INSERT, 32'hffff_ffff, 1'b1, 1'b0, STAT_DONE,    3);
    add_row(OP_INSERT, 32'h0000_0001, 1'b0, 1'b0, STAT_DONE,    0);
    add_row(OP_INSERT, 32'h0000_0002, 1'b0, 1'b0, STAT_DONE,    0);
    add_row(OP_INSERT, 32'h0000_0100, 1'b0, 1'b0, STAT_DONE,    0);
    add_row(OP_INSERT, 32'h0000_8000, 1'b0, 1'b0, STAT_DONE,    0);
    add_row(OP_INSERT, 32'h0001_0000, 1'b0, 1'b0, STAT_DONE,    0);
    add_row(OP_INSERT, 32'h5555_5555, 1'b0, 1'b0, STAT_DONE,    0);
    add_row(OP_INSERT, 32'haaaa_aaaa, 1'b0, 1'b0, STAT_DONE,    0);
    add_row(OP_INSERT, 32'h1234_5678, 1'b0, 1'b0, STAT_DONE,    0);
    add_row(OP_INSERT, 32'hfedc_ba98, 1'b0, 1'b0, STAT_DONE,    0);
    add_row(OP_INSERT, 32'h7fff_0000, 1'b0, 1'b0, STAT_DONE,    0);
    add_row(OP_INSERT, 32'h8000_ffff, 1'b0, 1'b0, STAT_DONE,    0);
    add_row(OP_INSERT, 32'h0f0f_0f0f, 1'b0, 1'b0, STAT_DONE,    0);
    add_row(OP_INSERT, 32'hf0f0_f0f0, 1'b0, 1'b0, STAT_DONE,    0);
    add_row(OP_INSERT, 32'h3333_3333, 1'b1, 1'b0, STAT_FULL,    16);
    add_row(OP_INSERT, 32'h7fff_ffff, 1'b1, 1'b1, STAT_PRESENT, 16);
    add_row(OP_CLEAR,  32'hffff_ffff, 1'b1, 1'b0, STAT_DONE,    0);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_request(row.op, row.key, row.typed, row.want);
    end

    filling = 1'b1;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2 || $urandom_range(99) == 0) begin
        drain_pending();
      end else if ((n / 80) % 3 != 2) begin
        r   = $urandom_range(99);
        gap = (r < 60) ? 0 : (r < 92) ? $urandom_range(3, 1) : $urandom_range(40, 10);
        idle_for(gap);
      end

      if (keys_held == SLOTS && $urandom_range(3) == 0) filling = 1'b0;
      else if (keys_held == 0) filling = 1'b1;
      else if ($urandom_range(49) == 0) filling = !filling;

      r = $urandom_range(99);
      if (r < 1) op = OP_CLEAR;
      else if (r < 22) op = OP_SEARCH;
      else if (r < 72) op = filling ? OP_INSERT : OP_DELETE;
      else op = filling ? OP_DELETE : OP_INSERT;

      r = $urandom_range(99);
      if (r < 45) begin
        k = key_pool[$urandom_range(POOL_SIZE - 1)];
      end else if (r < 80) begin
        slot = $urandom_range(SLOTS - 1);
        k = slot_used[slot] ? held_keys[slot] : key_pool[$urandom_range(POOL_SIZE - 1)];
      end else begin
        k = $urandom();
      end

      send_request(op, k, 1'b0, '0);
    end

    drain_pending();
    repeat (SLOTS + 8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS key_set_table_unit");
    end else begin
      $display("FAIL key_set_table_unit");
    end
    $finish;
  end

endmodule
